>>> rtl/fnclog_pkg.sv
// ----------------------------------------------------------------------------
// fnclog_pkg
// Shared types, constants and single-precision arithmetic helpers for the
// logarithm unit. Helpers cover normal numbers and zeros only.
// ----------------------------------------------------------------------------
package fnclog_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_BITS    = 26;

  localparam logic [31:0] POS_INF    = 32'h7F800000;
  localparam logic [31:0] NEG_INF    = 32'hFF800000;
  localparam logic [22:0] SQRT_HALF_MANT = 23'h3504F3;
  localparam logic [31:0] F_HALF     = 32'h3F000000;
  localparam logic [31:0] F_NEG_HALF = 32'hBF000000;
  localparam logic [31:0] F_A0       = 32'hBF0D7E3D;
  localparam logic [31:0] F_B0       = 32'hBF29CC2F;
  localparam logic [31:0] F_B1       = 32'hBDCCCCCD;
  localparam logic [31:0] F_LN2_HI   = 32'h3F318000;
  localparam logic [31:0] F_LN2_LO   = 32'hB95E8083;
  localparam logic [31:0] F_LOG10E   = 32'h3EDE5BD9;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_res;
    logic        base10;
    logic        hibr;
    logic [31:0] f;
    logic [31:0] xn;
  } entry_t;

  // working values carried down the back pipeline
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_res;
    logic        base10;
    logic        hibr;
    logic [31:0] f;
    logic [31:0] xn;
    logic [31:0] a;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] znum;
    logic [31:0] t2;
    logic [31:0] zden;
    logic [31:0] z;
    logic [31:0] w;
    logic [31:0] aw;
    logic [31:0] tb;
    logic [31:0] bw;
    logic [31:0] rz2;
    logic [31:0] t;
    logic [31:0] rz;
    logic [31:0] acc;
  } ctx_t;

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [9:0]  e;
    logic [24:0] rem;
    logic [23:0] dm;
    logic [25:0] quo;
  } div_st_t;

  // round to nearest even and pack; m carries the hidden bit
  function automatic logic [31:0] round_pack(input logic s, input logic [9:0] e,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
    logic        up;
    logic [24:0] mr;
    logic [9:0]  eo;
    logic [22:0] frac;
    up = g & (st | m[0]);
    mr = {1'b0, m} + {24'd0, up};
    if (mr[24]) begin
      eo   = e + 10'd1;
      frac = mr[23:1];
    end else begin
      eo   = e;
      frac = mr[22:0];
    end
    return {s, eo[7:0], frac};
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  d;
    logic [26:0] ma;
    logic [26:0] mb;
    logic [26:0] mbs;
    logic [27:0] sum;
    logic [26:0] m;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic        sticky;
    if (x[30:23] == 8'd0 && y[30:23] == 8'd0) begin
      return {x[31] & y[31], 31'd0};
    end
    if (x[30:23] == 8'd0) begin
      return y;
    end
    if (y[30:23] == 8'd0) begin
      return x;
    end
    if (x[30:0] < y[30:0]) begin
      a = y;
      b = x;
    end else begin
      a = x;
      b = y;
    end
    d  = a[30:23] - b[30:23];
    ma = {1'b1, a[22:0], 3'b000};
    mb = {1'b1, b[22:0], 3'b000};
    if (d >= 8'd27) begin
      mbs = 27'd1;
    end else begin
      sticky = (mb & ((27'd1 << d) - 27'd1)) != 27'd0;
      mbs    = (mb >> d) | {26'd0, sticky};
    end
    if (a[31] == b[31]) begin
      sum = {1'b0, ma} + {1'b0, mbs};
    end else begin
      sum = {1'b0, ma} - {1'b0, mbs};
    end
    if (sum == 28'd0) begin
      return 32'd0;
    end
    e  = {2'b00, a[30:23]};
    lz = 5'd0;
    if (sum[27]) begin
      m = {sum[27:2], sum[1] | sum[0]};
      e = e + 10'd1;
    end else begin
      for (int i = 0; i < 27; i++) begin
        if (sum[i]) begin
          lz = 5'(26 - i);
        end
      end
      m = sum[26:0] << lz;
      e = e - {5'd0, lz};
    end
    return round_pack(a[31], e, m[26:3], m[2], m[1] | m[0]);
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    logic [47:0] p;
    logic [9:0]  e;
    s = x[31] ^ y[31];
    if (x[30:23] == 8'd0 || y[30:23] == 8'd0) begin
      return {s, 31'd0};
    end
    p = {24'd0, 1'b1, x[22:0]} * {24'd0, 1'b1, y[22:0]};
    e = {2'b00, x[30:23]} + {2'b00, y[30:23]} - 10'd127;
    if (p[47]) begin
      return round_pack(s, e + 10'd1, p[47:24], p[23], p[22:0] != 23'd0);
    end
    return round_pack(s, e, p[46:23], p[22], p[21:0] != 22'd0);
  endfunction

  function automatic div_st_t div_unpack(input logic [31:0] x, input logic [31:0] y);
    div_st_t r;
    r.sign = x[31] ^ y[31];
    r.zero = x[30:23] == 8'd0;
    r.e    = {2'b00, x[30:23]} - {2'b00, y[30:23]} + 10'd127;
    r.rem  = {2'b01, x[22:0]};
    r.dm   = {1'b1, y[22:0]};
    r.quo  = '0;
    return r;
  endfunction

  // one restoring step: one quotient bit
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     r;
    logic [24:0] rn;
    logic        bit_q;
    r     = s;
    bit_q = s.rem >= {1'b0, s.dm};
    rn    = bit_q ? (s.rem - {1'b0, s.dm}) : s.rem;
    r.rem = {rn[23:0], 1'b0};
    r.quo = {s.quo[24:0], bit_q};
    return r;
  endfunction

  function automatic logic [31:0] div_round(input div_st_t s);
    logic st;
    st = s.rem != 25'd0;
    if (s.zero) begin
      return {s.sign, 31'd0};
    end
    if (s.quo[25]) begin
      return round_pack(s.sign, s.e, s.quo[25:2], s.quo[1], s.quo[0] | st);
    end
    return round_pack(s.sign, s.e - 10'd1, s.quo[24:1], s.quo[0], st);
  endfunction

endpackage

>>> rtl/fnclog_front.sv
// ----------------------------------------------------------------------------
// fnclog_front
// Accepts operands, screens special values and splits x into f and N.
// ----------------------------------------------------------------------------
module fnclog_front import fnclog_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_ready,
  input  logic        action,
  input  logic [31:0] operand_bits,
  output logic        ent_valid,
  input  logic        ent_ready,
  output entry_t      ent
);

  logic        fv;
  entry_t      fe;
  entry_t      fe_next;
  logic [7:0]  expo;
  logic [8:0]  n;
  logic [7:0]  mag;
  logic [2:0]  p;
  logic [23:0] full;

  assign expo = operand_bits[30:23];

  always_comb begin
    fe_next.base10 = action;
    fe_next.hibr   = operand_bits[22:0] > SQRT_HALF_MANT;
    fe_next.f      = {1'b0, 8'd126, operand_bits[22:0]};
    fe_next.spec   = (expo == 8'hFF) || operand_bits[31] || (expo == 8'd0);
    if (expo == 8'hFF && operand_bits[22:0] == 23'd0 && !operand_bits[31]) begin
      fe_next.spec_res = POS_INF;
    end else begin
      fe_next.spec_res = NEG_INF;
    end
    // N = expo - 126, one less on the low branch
    n   = {1'b0, expo} - 9'd126 - {8'd0, !fe_next.hibr};
    mag = n[8] ? 8'(-n) : n[7:0];
    p   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) begin
        p = 3'(i);
      end
    end
    full = {mag, 16'd0} << (3'd7 - p);
    if (mag == 8'd0) begin
      fe_next.xn = 32'd0;
    end else begin
      fe_next.xn = {n[8], 8'd127 + {5'd0, p}, full[22:0]};
    end
  end

  assign operand_ready = !fv || ent_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (operand_ready) begin
      fv <= operand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operand_ready && operand_valid) begin
      fe <= fe_next;
    end
  end

  assign ent_valid = fv;
  assign ent       = fe;

endmodule

>>> rtl/fnclog_fifo.sv
// ----------------------------------------------------------------------------
// fnclog_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module fnclog_fifo import fnclog_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/fnclog_div.sv
// ----------------------------------------------------------------------------
// fnclog_div
// Pipelined single-precision divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fnclog_div import fnclog_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  ctx_t        in_ctx,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_v,
  output ctx_t        out_ctx,
  output logic [31:0] quot
);

  logic    v  [DIV_BITS+2];
  div_st_t ds [DIV_BITS+1];
  ctx_t    dc [DIV_BITS+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_BITS + 2; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_v;
      for (int i = 0; i < DIV_BITS + 1; i++) begin
        v[i+1] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= div_unpack(num, den);
      dc[0] <= in_ctx;
      for (int i = 0; i < DIV_BITS; i++) begin
        ds[i+1] <= div_step(ds[i]);
      end
      for (int i = 0; i < DIV_BITS + 1; i++) begin
        dc[i+1] <= dc[i];
      end
      quot <= div_round(ds[DIV_BITS]);
    end
  end

  assign out_v   = v[DIV_BITS+1];
  assign out_ctx = dc[DIV_BITS+1];

endmodule

>>> rtl/fnclog_back.sv
// ----------------------------------------------------------------------------
// fnclog_back
// Arithmetic pipeline: reduced argument, rational fit, N*ln2 and scaling.
// ----------------------------------------------------------------------------
module fnclog_back import fnclog_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ent_valid,
  output logic        ent_ready,
  input  entry_t      ent,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result_bits
);

  logic        en;
  logic        r1v, r2v, r3v, r4v, r5v, r6v, r7v, r8v, r9v, r10v, r11v, r12v;
  ctx_t        r1, r2, r3, r4, r5, r6, r7, r8, r9, r10, r11, r12;
  ctx_t        n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12;
  logic        d1v, d2v;
  ctx_t        d1c, d2c;
  logic [31:0] d1q, d2q;
  logic [31:0] res_next;

  // advance everything unless a result is waiting and not taken
  assign en        = !result_valid || result_ready;
  assign ent_ready = en;

  always_comb begin
    n1          = '0;
    n1.spec     = ent.spec;
    n1.spec_res = ent.spec_res;
    n1.base10   = ent.base10;
    n1.hibr     = ent.hibr;
    n1.f        = ent.f;
    n1.xn       = ent.xn;
    n1.a        = fadd(ent.f, F_NEG_HALF);
    n1.lo       = fmul(ent.xn, F_LN2_LO);

    n2      = r1;
    n2.znum = r1.hibr ? fadd(r1.a, F_NEG_HALF) : r1.a;
    n2.t2   = fmul(r1.hibr ? r1.f : r1.a, F_HALF);
    n2.hi   = fmul(r1.xn, F_LN2_HI);

    n3      = r2;
    n3.zden = fadd(r2.t2, F_HALF);

    n4   = d1c;
    n4.z = d1q;
    n4.w = fmul(d1q, d1q);

    n5    = r4;
    n5.aw = fadd(r4.w, F_A0);
    n5.tb = fadd(r4.w, F_B1);

    n6    = r5;
    n6.tb = fmul(r5.tb, r5.w);

    n7    = r6;
    n7.bw = fadd(r6.tb, F_B0);

    n8     = d2c;
    n8.rz2 = fmul(d2c.w, d2q);

    n9   = r8;
    n9.t = fmul(r8.z, r8.rz2);

    n10    = r9;
    n10.rz = fadd(r9.z, r9.t);

    n11     = r10;
    n11.acc = fadd(r10.lo, r10.rz);

    n12     = r11;
    n12.acc = fadd(r11.acc, r11.hi);

    if (r12.spec) begin
      res_next = r12.spec_res;
    end else if (r12.base10) begin
      res_next = fmul(r12.acc, F_LOG10E);
    end else begin
      res_next = r12.acc;
    end
  end

  fnclog_div u_div_z (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (r3v),
    .in_ctx (r3),
    .num    (r3.znum),
    .den    (r3.zden),
    .out_v  (d1v),
    .out_ctx(d1c),
    .quot   (d1q)
  );

  fnclog_div u_div_q (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (r7v),
    .in_ctx (r7),
    .num    (r7.aw),
    .den    (r7.bw),
    .out_v  (d2v),
    .out_ctx(d2c),
    .quot   (d2q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r1v <= 1'b0; r2v <= 1'b0; r3v <= 1'b0; r4v <= 1'b0;
      r5v <= 1'b0; r6v <= 1'b0; r7v <= 1'b0; r8v <= 1'b0;
      r9v <= 1'b0; r10v <= 1'b0; r11v <= 1'b0; r12v <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      r1v  <= ent_valid;
      r2v  <= r1v;
      r3v  <= r2v;
      r4v  <= d1v;
      r5v  <= r4v;
      r6v  <= r5v;
      r7v  <= r6v;
      r8v  <= d2v;
      r9v  <= r8v;
      r10v <= r9v;
      r11v <= r10v;
      r12v <= r11v;
      result_valid <= r12v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1  <= n1;
      r2  <= n2;
      r3  <= n3;
      r4  <= n4;
      r5  <= n5;
      r6  <= n6;
      r7  <= n7;
      r8  <= n8;
      r9  <= n9;
      r10 <= n10;
      r11 <= n11;
      r12 <= n12;
      result_bits <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en && r3v |=> r3v && $stable(r3.zden))
    else $error("stage 3 changed while stalled");

  a_z_small: assert property (@(posedge clk) disable iff (rst)
    d1v && !d1c.spec |-> d1q[30:23] < 8'd127)
    else $error("reduced argument out of range");

  a_finite: assert property (@(posedge clk) disable iff (rst)
    en && r12v && !r12.spec |=> result_bits[30:23] != 8'hFF)
    else $error("ordinary operand gave a non-finite result");
`endif

endmodule

>>> rtl/float_natural_and_common_log.sv
// Throughput: one operand per cycle while the result side accepts; every stage,
// including both dividers (one quotient bit per stage), is fully pipelined.
// The result side stalls the whole back pipeline; the queue lets the front
// keep taking operands meanwhile, until the queue is full.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// float_natural_and_common_log
// Single-precision natural or base-10 logarithm.
// ----------------------------------------------------------------------------
module float_natural_and_common_log import fnclog_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_ready,
  input  logic        action,
  input  logic [31:0] operand_bits,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result_bits
);

  logic   fe_valid;
  logic   fe_ready;
  entry_t fe_data;
  logic   q_valid;
  logic   q_ready;
  entry_t q_data;

  fnclog_front u_front (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .action       (action),
    .operand_bits (operand_bits),
    .ent_valid    (fe_valid),
    .ent_ready    (fe_ready),
    .ent          (fe_data)
  );

  fnclog_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fe_valid),
    .push_ready(fe_ready),
    .push_data (fe_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  fnclog_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ent_valid   (q_valid),
    .ent_ready   (q_ready),
    .ent         (q_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_bits (result_bits)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Logarithm unit testbench
// Feeds directed and random single-precision operands in both modes through
// the valid/ready ports with random gaps and back-pressure, including one long
// receiver hold-off. A bit-exact float model predicts each result, and every
// result transfer is compared in order against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic ACT_LN    = 1'b0;
  localparam logic ACT_LOG10 = 1'b1;
  localparam int   N_RANDOM  = 1200;
  localparam int   HOLD_LEN  = 400;

  localparam logic [31:0] K_HALF    = 32'h3F000000;
  localparam logic [22:0] K_RT_HALF = 23'h3504F3;
  localparam logic [31:0] K_A0      = 32'hBF0D7E3D;
  localparam logic [31:0] K_B0      = 32'hBF29CC2F;
  localparam logic [31:0] K_B1      = 32'hBDCCCCCD;
  localparam logic [31:0] K_LN2_HI  = 32'h3F318000;
  localparam logic [31:0] K_LN2_LO  = 32'hB95E8083;
  localparam logic [31:0] K_LOG10E  = 32'h3EDE5BD9;
  localparam logic [31:0] BITS_PINF = 32'h7F800000;
  localparam logic [31:0] BITS_NINF = 32'hFF800000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        operand_valid = 1'b0;
  logic        operand_ready;
  logic        action = ACT_LN;
  logic [31:0] operand_bits = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] result_bits;

  typedef struct {
    logic        act;
    logic [31:0] bits;
  } operand_t;

  operand_t    pending_ops[$];
  logic [31:0] log_expected[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_total = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  bit          stim_done = 1'b0;

  float_natural_and_common_log u_dut (
    .clk(clk), .rst(rst),
    .operand_valid(operand_valid), .operand_ready(operand_ready),
    .action(action), .operand_bits(operand_bits),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_bits(result_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round v * 2^e0 (v nonzero) to single precision, nearest even
  function automatic logic [31:0] f_round(input logic s, input int e0, input logic [63:0] v);
    int          p;
    int          sh;
    int          eb;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    p = 63;
    while (!v[p]) p--;
    if (p <= 23) begin
      m = v << (23 - p);
    end else begin
      sh   = p - 23;
      m    = v >> sh;
      rem  = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    eb = p + e0 + 127;
    if (m[24]) begin
      m  = m >> 1;
      eb = eb + 1;
    end
    return {s, eb[7:0], m[22:0]};
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] va;
    logic [63:0] vb;
    logic [63:0] full;
    logic [63:0] sum;
    int          d;
    if (x[30:23] == 8'd0 && y[30:23] == 8'd0) return {x[31] & y[31], 31'd0};
    if (x[30:23] == 8'd0) return y;
    if (y[30:23] == 8'd0) return x;
    if (x[30:0] < y[30:0]) begin
      a = y;
      b = x;
    end else begin
      a = x;
      b = y;
    end
    d  = int'(a[30:23]) - int'(b[30:23]);
    va = {40'd0, 1'b1, a[22:0]} << 30;
    if (d >= 54) begin
      vb = 64'd1;
    end else begin
      full = {40'd0, 1'b1, b[22:0]} << 30;
      vb   = full >> d;
      if ((vb << d) != full) vb = vb | 64'd1;
    end
    sum = (a[31] == b[31]) ? va + vb : va - vb;
    if (sum == 64'd0) return 32'd0;
    return f_round(a[31], int'(a[30:23]) - 180, sum);
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    logic [63:0] p;
    s = x[31] ^ y[31];
    if (x[30:23] == 8'd0 || y[30:23] == 8'd0) return {s, 31'd0};
    p = {40'd0, 1'b1, x[22:0]} * {40'd0, 1'b1, y[22:0]};
    return f_round(s, int'(x[30:23]) + int'(y[30:23]) - 300, p);
  endfunction

  function automatic logic [31:0] f_div(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] r;
    s = x[31] ^ y[31];
    if (x[30:23] == 8'd0) return {s, 31'd0};
    num = {40'd0, 1'b1, x[22:0]} << 40;
    den = {40'd0, 1'b1, y[22:0]};
    q   = num / den;
    r   = num % den;
    return f_round(s, int'(x[30:23]) - int'(y[30:23]) - 41, {q[62:0], r != 64'd0});
  endfunction

  function automatic logic [31:0] f_from_int(input int n);
    if (n == 0) return 32'd0;
    return f_round(n < 0, 0, 64'(n < 0 ? -n : n));
  endfunction

  function automatic logic [31:0] log_predict(input logic act, input logic [31:0] xb);
    int          n;
    logic [31:0] f, znum, zden, t, z, w, aw, bw, q, rz, xn, acc;
    if (xb[30:23] == 8'hFF) return (xb[22:0] == 23'd0 && !xb[31]) ? BITS_PINF : BITS_NINF;
    if (xb[31] || xb[30:23] == 8'd0) return BITS_NINF;
    n = int'(xb[30:23]) - 126;
    f = {1'b0, 8'd126, xb[22:0]};
    if (xb[22:0] > K_RT_HALF) begin
      t    = f_add(f, {1'b1, K_HALF[30:0]});
      znum = f_add(t, {1'b1, K_HALF[30:0]});
      t    = f_mul(f, K_HALF);
      zden = f_add(t, K_HALF);
    end else begin
      n    = n - 1;
      znum = f_add(f, {1'b1, K_HALF[30:0]});
      t    = f_mul(znum, K_HALF);
      zden = f_add(t, K_HALF);
    end
    z   = f_div(znum, zden);
    w   = f_mul(z, z);
    aw  = f_add(w, K_A0);
    t   = f_add(w, K_B1);
    t   = f_mul(t, w);
    bw  = f_add(t, K_B0);
    q   = f_div(aw, bw);
    t   = f_mul(w, q);
    t   = f_mul(z, t);
    rz  = f_add(z, t);
    xn  = f_from_int(n);
    acc = f_add(f_mul(xn, K_LN2_LO), rz);
    acc = f_add(acc, f_mul(xn, K_LN2_HI));
    if (act == ACT_LOG10) acc = f_mul(acc, K_LOG10E);
    return acc;
  endfunction

  function automatic int pick_gap(input bit busy_phase);
    int r;
    r = $urandom_range(0, 99);
    if (busy_phase || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_op(input logic act, input logic [31:0] bits);
    operand_t op;
    op.act  = act;
    op.bits = bits;
    pending_ops.push_back(op);
    n_total++;
  endtask

  task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: result_bits %h, expected %h", $realtime, got, want);
    n_errors++;
  endtask

  // sender: hold the item until transfer, then pause or move on
  always @(posedge clk) begin
    if (rst) begin
      operand_valid <= 1'b0;
    end else begin
      if (operand_valid && operand_ready) begin
        log_expected.push_back(log_predict(action, operand_bits));
        n_sent++;
      end
      if (!operand_valid || operand_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          operand_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          operand_t op;
          op = pending_ops.pop_front();
          action        <= op.act;
          operand_bits  <= op.bits;
          operand_valid <= 1'b1;
          send_gap = pick_gap((n_sent / 150) % 3 == 1);
        end else begin
          operand_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer, stall at random, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (log_expected.size() == 0) begin
          $display("unexpected result %h at %0t", result_bits, $realtime);
          n_errors++;
        end else begin
          logic [31:0] want;
          want = log_expected.pop_front();
          if (result_bits !== want) report_mismatch(result_bits, want);
        end
      end
      if (!hold_done && n_sent >= 300) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        recv_gap = pick_gap((n_sent / 150) % 3 == 1);
      end
    end
  end

  initial begin
    logic [31:0] r;
    logic        a;
    // special values and edges, both modes
    for (int m = 0; m < 2; m++) begin
      a = m[0];
      add_op(a, 32'h00000000);
      add_op(a, 32'h80000000);
      add_op(a, 32'hBF800000);
      add_op(a, BITS_NINF);
      add_op(a, BITS_PINF);
      add_op(a, 32'h7FC00001);
      add_op(a, 32'hFFFFFFFF);
      add_op(a, 32'h007FFFFF);
      add_op(a, 32'h3F800000);
      add_op(a, 32'h00800000);
      add_op(a, 32'h7F7FFFFF);
      add_op(a, {1'b0, 8'd126, K_RT_HALF});
      add_op(a, {1'b0, 8'd126, K_RT_HALF + 23'd1});
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      a = 1'($urandom_range(0, 1));
      r = $urandom;
      if ($urandom_range(0, 9) < 8) begin
        r[31] = 1'b0;
        if (r[30:23] == 8'd0 || r[30:23] == 8'hFF) r[30:23] = 8'($urandom_range(1, 254));
        if ($urandom_range(0, 3) == 0) r[30:23] = 8'($urandom_range(120, 133));
      end
      add_op(a, r);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (n_sent == n_total && pending_ops.size() == 0);
    wait (log_expected.size() == 0);
    repeat (150) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS float_natural_and_common_log");
    end else begin
      $display("FAIL float_natural_and_common_log");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL float_natural_and_common_log");
    $finish;
  end

endmodule
